FILE: rtl/token_bucket_rate_limiter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the token bucket rate limiter
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_RATE_LIMITER_TOP_DEFINES_SVH
`define TOKEN_BUCKET_RATE_LIMITER_TOP_DEFINES_SVH

// condition must hold at every edge out of reset
`define TBRL_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TBRL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/tbrl_pkg.sv
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared types and constants of the token bucket rate limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbrl_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_TIME_BITS = 48;

    localparam int OP_W    = 2;
    localparam int RATE_W  = 32;
    localparam int CAP_W   = 24;
    localparam int TOK_W   = 24;
    localparam int WAIT_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CHUNK_W = 16;

    localparam logic [0:0] CFG_RATE = 1'b0;
    localparam logic [0:0] CFG_CAP  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_CONSUME = 2'd0,
        OP_PROBE   = 2'd1,
        OP_WAIT    = 2'd2,
        OP_AVAIL   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PROJ,
        ST_ACT,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/token_bucket_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// Token bucket rate limiter
// Refills at a Q16.16 rate per tick up to an integer capacity and answers
// consume, probe, wait-time and available-token requests.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* channel takes one item (opcode, tokens, now_time); m_* returns one
//    result item (granted, wait_ticks, available_tokens) per item, in order.
//  - cfg_* writes rate_per_tick (index 0) or capacity (index 1); write only
//    while no item is in flight. cfg_ready is always high.
//  - A two-entry queue sits between the classifier and the engine, so two
//    items are taken while the engine or the receiver is stalled.
//  - Items answered without the bucket (limiting off, or zero tokens on a
//    request other than an available query) skip the refill. Others
//    refill from E elapsed-time bits, E = 26 + FRAC_BITS (+ 16 - FRAC_BITS
//    when FRAC_BITS < 16), by one 32x16 partial product per cycle.
//  - Wait queries with a deficit also run a bit-serial divider of width
//    NUM_W = 25 + FRAC_BITS (+ 16 - FRAC_BITS when below 16), 41 at default.
//  - One item is in the engine at a time, until its result is passed on.
//  - Reset: rate 0 (limiting off), capacity 1, bucket full, time mark zero.
//  - m_valid holds with its result until m_ready; the engine then waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_bucket_rate_limiter_top #(
    parameter int FRAC_BITS = tbrl_pkg::DEF_FRAC_BITS,
    parameter int TIME_BITS = tbrl_pkg::DEF_TIME_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tbrl_pkg::OP_W-1:0]   s_opcode,
    input  logic [tbrl_pkg::TOK_W-1:0]  s_tokens,
    input  logic [TIME_BITS-1:0]        s_now_time,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_granted,
    output logic [tbrl_pkg::WAIT_W-1:0] m_wait_ticks,
    output logic [tbrl_pkg::TOK_W-1:0]  m_available_tokens,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [0:0]                  cfg_index,
    input  logic [tbrl_pkg::CFG_W-1:0]  cfg_data
);
    import tbrl_pkg::*;

    `include "token_bucket_rate_limiter_top_defines.svh"

    localparam int ITEM_W = 2 * TOK_W + OP_W + TIME_BITS + 1;

    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [ITEM_W-1:0] f_item;
    logic              q_valid;
    logic              q_ready;
    logic [ITEM_W-1:0] q_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        rate_next = rate_reg;
        cap_next  = cap_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_RATE) begin
                rate_next = cfg_data[RATE_W-1:0];
            end else begin
                // zero capacity reads as one
                cap_next = (cfg_data[CAP_W-1:0] == '0) ? CAP_W'(1) : cfg_data[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= '0;
            cap_reg  <= CAP_W'(1);
        end else begin
            rate_reg <= rate_next;
            cap_reg  <= cap_next;
        end
    end

    tbrl_front #(
        .TIME_BITS (TIME_BITS),
        .ITEM_W    (ITEM_W)
    ) u_front (
        .s_opcode   (s_opcode),
        .s_tokens   (s_tokens),
        .s_now_time (s_now_time),
        .rate       (rate_reg),
        .capacity   (cap_reg),
        .item       (f_item)
    );

    tbrl_queue #(
        .W (ITEM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    tbrl_back #(
        .FRAC_BITS (FRAC_BITS),
        .TIME_BITS (TIME_BITS),
        .ITEM_W    (ITEM_W)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .rate               (rate_reg),
        .capacity           (cap_reg),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_data             (q_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_granted          (m_granted),
        .m_wait_ticks       (m_wait_ticks),
        .m_available_tokens (m_available_tokens)
    );

    `TBRL_ASSERT_ALWAYS(a_cap_nonzero, aclk, aresetn, cap_reg != '0, "capacity is zero")
    `TBRL_ASSERT_IMPLY(a_grant_excl, aclk, aresetn, m_valid && m_granted, m_wait_ticks == '0 && m_available_tokens == '0, "grant with other fields set")
    `TBRL_ASSERT_IMPLY(a_rate_off, aclk, aresetn, m_valid && rate_reg == '0, m_granted || (m_wait_ticks == '0 && m_available_tokens == '0), "disabled limiter gave wait or tokens")

endmodule

FILE: rtl/tbrl_queue.sv
// ----------------------------------------------------------------------------
// tbrl_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbrl_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/tbrl_front.sv
// ----------------------------------------------------------------------------
// tbrl_front
// Classifies incoming items: clamps the request to capacity and flags
// items answered without touching the bucket.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbrl_front #(
    parameter int TIME_BITS = tbrl_pkg::DEF_TIME_BITS,
    parameter int ITEM_W    = 2 * tbrl_pkg::TOK_W + tbrl_pkg::OP_W + TIME_BITS + 1
) (
    input  logic [tbrl_pkg::OP_W-1:0]   s_opcode,
    input  logic [tbrl_pkg::TOK_W-1:0]  s_tokens,
    input  logic [TIME_BITS-1:0]        s_now_time,
    input  logic [tbrl_pkg::RATE_W-1:0] rate,
    input  logic [tbrl_pkg::CAP_W-1:0]  capacity,
    output logic [ITEM_W-1:0]           item
);
    import tbrl_pkg::*;

    logic [TOK_W-1:0] req;
    logic             fast;
    logic             rate_off;

    always_comb begin
        rate_off = (rate == '0);
        req      = (s_tokens < capacity) ? s_tokens : capacity;
        // disabled limiting or zero tokens answers at once; an available
        // query answers at once only when limiting is disabled
        if (op_t'(s_opcode) == OP_AVAIL) begin
            fast = rate_off;
        end else begin
            fast = rate_off || (s_tokens == '0);
        end
        item = {s_opcode, s_tokens, req, s_now_time, fast};
    end

endmodule

FILE: rtl/tbrl_back.sv
// ----------------------------------------------------------------------------
// tbrl_back
// Bucket engine: refill by chunked multiply, projection, decision, and a
// bit-serial divider for wait queries. Holds the bucket state and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbrl_back #(
    parameter int FRAC_BITS = tbrl_pkg::DEF_FRAC_BITS,
    parameter int TIME_BITS = tbrl_pkg::DEF_TIME_BITS,
    parameter int ITEM_W    = 2 * tbrl_pkg::TOK_W + tbrl_pkg::OP_W + TIME_BITS + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tbrl_pkg::RATE_W-1:0] rate,
    input  logic [tbrl_pkg::CAP_W-1:0]  capacity,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic [ITEM_W-1:0]           q_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_granted,
    output logic [tbrl_pkg::WAIT_W-1:0] m_wait_ticks,
    output logic [tbrl_pkg::TOK_W-1:0]  m_available_tokens
);
    import tbrl_pkg::*;

    localparam int SD     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int SU     = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int BAL_W  = CAP_W + 2 + FRAC_BITS;
    localparam int EL_W   = BAL_W + SD;
    localparam int CH     = (EL_W + CHUNK_W - 1) / CHUNK_W;
    localparam int EP_W   = CH * CHUNK_W;
    localparam int ACC_W  = EP_W + RATE_W;
    localparam int P_W    = ACC_W - SD + SU;
    localparam int XW     = (TIME_BITS > EP_W) ? TIME_BITS : EP_W;
    localparam int NUM_W  = CAP_W + 1 + FRAC_BITS + SD;
    localparam int DEN_W  = RATE_W + SU;
    localparam int CNT_W  = $clog2(NUM_W);

    // unpacked item
    logic [OP_W-1:0]      i_op;
    logic [TOK_W-1:0]     i_tok;
    logic [TOK_W-1:0]     i_req;
    logic [TIME_BITS-1:0] i_now;
    logic                 i_fast;

    state_t state_reg, state_next;

    op_t                     op_reg, op_next;
    logic [TOK_W-1:0]        tok_reg, tok_next;
    logic [TOK_W-1:0]        req_reg, req_next;
    logic [TIME_BITS-1:0]    now_reg, now_next;
    logic [EP_W-1:0]         elap_reg, elap_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [BAL_W-1:0] proj_reg, proj_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [NUM_W-1:0]        quo_reg, quo_next;
    logic signed [BAL_W-1:0] bal_reg, bal_next;
    logic [TIME_BITS-1:0]    last_reg, last_next;
    logic                    res_gr_reg, res_gr_next;
    logic [WAIT_W-1:0]       res_wait_reg, res_wait_next;
    logic [TOK_W-1:0]        res_av_reg, res_av_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_gr_reg, m_gr_next;
    logic [WAIT_W-1:0]       m_wait_reg, m_wait_next;
    logic [TOK_W-1:0]        m_av_reg, m_av_next;

    // datapath temporaries
    logic [TIME_BITS-1:0]    el;
    logic [XW-1:0]           elx;
    logic [RATE_W+CHUNK_W-1:0] prod;
    logic signed [BAL_W-1:0] cq;
    logic signed [BAL_W:0]   hr;
    logic [P_W-1:0]          p_w;
    logic signed [BAL_W-1:0] req_q;
    logic signed [BAL_W-1:0] tok_q;
    logic signed [BAL_W:0]   deficit;
    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
    logic [DEN_W:0]          rem_sh;
    logic [NUM_W:0]          q_up;
    logic                    ok;
    logic                    slot_free;
    logic                    div_last;
    logic                    mul_last;

    assign {i_op, i_tok, i_req, i_now, i_fast} = q_data;

    assign cq    = BAL_W'({capacity, {FRAC_BITS{1'b0}}});
    assign req_q = BAL_W'({req_reg, {FRAC_BITS{1'b0}}});
    assign tok_q = BAL_W'({tok_reg, {FRAC_BITS{1'b0}}});
    assign den   = DEN_W'({rate, {SU{1'b0}}});
    assign slot_free = !m_valid_reg || m_ready;
    assign mul_last  = (cnt_reg == '0);
    assign div_last  = (cnt_reg == '0);

    assign q_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_granted          = m_gr_reg;
    assign m_wait_ticks       = m_wait_reg;
    assign m_available_tokens = m_av_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = i_fast ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_last) begin
                    state_next = ST_PROJ;
                end
            end
            ST_PROJ: state_next = ST_ACT;
            ST_ACT: begin
                if (op_reg == OP_WAIT && deficit > 0) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: state_next = ST_DONE;
            ST_DONE: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        op_next       = op_reg;
        tok_next      = tok_reg;
        req_next      = req_reg;
        now_next      = now_reg;
        elap_next     = elap_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        proj_next     = proj_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        bal_next      = bal_reg;
        last_next     = last_reg;
        res_gr_next   = res_gr_reg;
        res_wait_next = res_wait_reg;
        res_av_next   = res_av_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_gr_next     = m_gr_reg;
        m_wait_next   = m_wait_reg;
        m_av_next     = m_av_reg;

        el      = (i_now > last_reg) ? i_now - last_reg : '0;
        elx     = XW'(el);
        prod    = rate * elap_reg[EP_W-1 -: CHUNK_W];
        hr      = {cq[BAL_W-1], cq} - {bal_reg[BAL_W-1], bal_reg};
        p_w     = P_W'(acc_reg >> SD) << SU;
        deficit = {req_q[BAL_W-1], req_q} - {proj_reg[BAL_W-1], proj_reg};
        num     = NUM_W'(deficit) << SD;
        ok      = (proj_reg >= req_q);
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        q_up    = (NUM_W+1)'(quo_reg) + (NUM_W+1)'(rem_reg != '0);

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    op_next       = op_t'(i_op);
                    tok_next      = i_tok;
                    req_next      = i_req;
                    now_next      = i_now;
                    // saturate elapsed time: beyond this the bucket fills anyway
                    if ((elx >> EL_W) != '0) begin
                        elap_next = EP_W'({EL_W{1'b1}});
                    end else begin
                        elap_next = EP_W'(elx[EL_W-1:0]);
                    end
                    acc_next      = '0;
                    cnt_next      = CNT_W'(CH - 1);
                    res_gr_next   = (op_t'(i_op) == OP_CONSUME) || (op_t'(i_op) == OP_PROBE);
                    res_wait_next = '0;
                    res_av_next   = '0;
                end
            end
            ST_MUL: begin
                acc_next  = (acc_reg << CHUNK_W) + ACC_W'(prod);
                elap_next = elap_reg << CHUNK_W;
                cnt_next  = cnt_reg - 1'b1;
            end
            ST_PROJ: begin
                if (bal_reg >= cq || p_w >= P_W'(hr[BAL_W-1:0])) begin
                    proj_next = cq;
                end else begin
                    proj_next = bal_reg + BAL_W'(p_w);
                end
            end
            ST_ACT: begin
                res_gr_next   = 1'b0;
                res_wait_next = '0;
                res_av_next   = '0;
                case (op_reg)
                    OP_CONSUME: begin
                        res_gr_next = ok;
                        bal_next    = ok ? proj_reg - tok_q : proj_reg;
                        if (now_reg > last_reg) begin
                            last_next = now_reg;
                        end
                    end
                    OP_PROBE: res_gr_next = ok;
                    OP_WAIT: begin
                        quo_next = num;
                        rem_next = '0;
                        cnt_next = CNT_W'(NUM_W - 1);
                    end
                    default: begin
                        if (proj_reg > 0) begin
                            res_av_next = proj_reg[FRAC_BITS +: TOK_W];
                        end
                    end
                endcase
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, den}) begin
                    rem_next = DEN_W'(rem_sh - {1'b0, den});
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            ST_FIN: begin
                if ((q_up >> WAIT_W) != '0) begin
                    res_wait_next = '1;
                end else begin
                    res_wait_next = q_up[WAIT_W-1:0];
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_gr_next    = res_gr_reg;
                    m_wait_next  = res_wait_reg;
                    m_av_next    = res_av_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            bal_reg     <= BAL_W'({1'b1, {FRAC_BITS{1'b0}}});
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            bal_reg     <= bal_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        tok_reg      <= tok_next;
        req_reg      <= req_next;
        now_reg      <= now_next;
        elap_reg     <= elap_next;
        acc_reg      <= acc_next;
        proj_reg     <= proj_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        res_gr_reg   <= res_gr_next;
        res_wait_reg <= res_wait_next;
        res_av_reg   <= res_av_next;
        m_gr_reg     <= m_gr_next;
        m_wait_reg   <= m_wait_next;
        m_av_reg     <= m_av_next;
    end

endmodule
